[rtl/quadric_surface_normal_top_defines.svh]
// Assertion macros shared by the quadric surface normal RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef QUADRIC_SURFACE_NORMAL_TOP_DEFINES_SVH
`define QUADRIC_SURFACE_NORMAL_TOP_DEFINES_SVH

// same-cycle implication
`define QSN_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define QSN_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/qsn_pkg.sv]
// Package for the quadric surface normal block: widths, opcodes, sideband struct
// and fixed-point helpers. No dependencies.
package qsn_pkg;

	localparam int COORD_BITS       = 21;
	localparam int NORMAL_FRAC_BITS = 14;
	localparam int FRAC_IN          = 10;
	localparam int VEC_BITS         = 63;
	localparam int OUTW             = 16;
	localparam int WW               = 34;
	localparam int UW               = 56;
	localparam int MW               = UW - 1;
	localparam int NMW              = 30;
	localparam int SUMW             = 2 * NMW + 2;
	localparam int ROOTW            = NMW + 1;
	localparam int QW               = NORMAL_FRAC_BITS + 1;
	localparam int NUMW             = NMW + NORMAL_FRAC_BITS + 1;

	typedef enum logic [1:0] {
		OP_SPHERE   = 2'd0,
		OP_CYLINDER = 2'd1,
		OP_CONE     = 2'd2,
		OP_PLANE    = 2'd3
	} op_t;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		logic                  plane;
		logic                  pdeg;
		logic [2:0][OUTW-1:0]  pn;
		logic [2:0]            neg;
		logic                  zero;
	} side_t;

	function automatic coord_t unpack_c(input logic [VEC_BITS-1:0] w, input int idx);
		unpack_c = coord_t'(w[idx*COORD_BITS +: COORD_BITS]);
	endfunction

	function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] x, input int s);
		logic [63:0] m;
		m = x[63] ? $unsigned(-x) : $unsigned(x);
		m = (m + (64'd1 << (s - 1))) >> s;
		rnd_shr = x[63] ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic signed [63:0] sat_sym(input logic signed [63:0] x, input int b);
		logic signed [63:0] lim;
		lim = (64'sd1 <<< b) - 64'sd1;
		if (x > lim) begin
			sat_sym = lim;
		end else if (x < -lim) begin
			sat_sym = -lim;
		end else begin
			sat_sym = x;
		end
	endfunction

endpackage

[rtl/qsn_geom.sv]
// Geometry pipeline: hit point, axis projection and axial correction (8 stages).
// Depends on qsn_pkg.
module qsn_geom
	import qsn_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  op_t                  opcode,
	input  logic [VEC_BITS-1:0]  ray_origin,
	input  logic [VEC_BITS-1:0]  ray_dir,
	input  logic [20:0]          hit_distance,
	input  logic [VEC_BITS-1:0]  obj_point,
	input  logic [VEC_BITS-1:0]  obj_axis,
	input  logic [15:0]          cone_slope,
	output logic                 out_valid,
	output logic [2:0][UW-1:0]   u_vec,
	output side_t                side
);
	localparam int CB   = COORD_BITS;
	localparam int DTW  = 2 * CB + 1;
	localparam int PW   = WW + CB;
	localparam int MSW  = 41;
	localparam int F12W = 21;
	localparam int PRW  = MSW + F12W + 1;
	localparam int GW   = 43;
	localparam int GVW  = 64;
	localparam int PSH  = NORMAL_FRAC_BITS - FRAC_IN;
	localparam int PSW  = CB + PSH;
	localparam logic signed [PSW-1:0] PONE = PSW'(1) <<< NORMAL_FRAC_BITS;
	localparam logic [F12W-1:0] F12_ONE = F12W'(1) << 12;

	coord_t                     o_c [3];
	coord_t                     d_c [3];
	coord_t                     c_c [3];
	coord_t                     v_c [3];
	logic signed [CB:0]         t_c;
	logic signed [PSW-1:0]      ps_c;
	side_t                      side_c;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	op_t op_s1, op_s2, op_s3, op_s4, op_s5, op_s6, op_s7;
	side_t side_s1, side_s2, side_s3, side_s4, side_s5, side_s6, side_s7, side_s8;
	logic signed [CB:0]      diff_s1 [3];
	logic signed [DTW-1:0]   dt_s1 [3];
	coord_t                  ax_s1 [3], ax_s2 [3], ax_s3 [3], ax_s4 [3], ax_s5 [3], ax_s6 [3];
	logic [31:0]             kk_s1;
	logic signed [WW-1:0]    w_s2 [3], w_s3 [3], w_s4 [3], w_s5 [3], w_s6 [3], w_s7 [3];
	logic [F12W-1:0]         f12_s2, f12_s3, f12_s4;
	logic signed [PW-1:0]    pr_s3 [3];
	logic signed [MSW-1:0]   m_s4;
	logic signed [PRW-1:0]   prod_s5;
	logic signed [GW-1:0]    g_s6;
	logic signed [GVW-1:0]   gv_s7 [3];
	logic [2:0][UW-1:0]      u_s8;

	always_comb begin
		t_c = $signed({1'b0, hit_distance[CB-1:0]});
		side_c = '0;
		side_c.plane = (opcode == OP_PLANE);
		side_c.pdeg = 1'b1;
		for (int i = 0; i < 3; i++) begin
			o_c[i] = unpack_c(ray_origin, i);
			d_c[i] = unpack_c(ray_dir, i);
			c_c[i] = unpack_c(obj_point, i);
			v_c[i] = unpack_c(obj_axis, i);
			if (v_c[i] != '0) begin
				side_c.pdeg = 1'b0;
			end
			ps_c = $signed({v_c[i], {PSH{1'b0}}});
			if (ps_c > PONE) begin
				ps_c = PONE;
			end else if (ps_c < -PONE) begin
				ps_c = -PONE;
			end
			side_c.pn[i] = OUTW'(ps_c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6; v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// hit point terms
			op_s1 <= opcode;
			side_s1 <= side_c;
			kk_s1 <= 32'(cone_slope) * 32'(cone_slope);
			for (int i = 0; i < 3; i++) begin
				diff_s1[i] <= (CB+1)'(o_c[i]) - (CB+1)'(c_c[i]);
				dt_s1[i] <= DTW'(d_c[i]) * DTW'(t_c);
				ax_s1[i] <= v_c[i];
			end
			// W = P - C at Q.10, slope factor
			op_s2 <= op_s1;
			side_s2 <= side_s1;
			f12_s2 <= (op_s1 == OP_CONE) ?
				F12_ONE + F12W'((33'(kk_s1) + 33'd2048) >> 12) : F12_ONE;
			for (int i = 0; i < 3; i++) begin
				w_s2[i] <= WW'(rnd_shr((64'(diff_s1[i]) <<< FRAC_IN) + 64'(dt_s1[i]), FRAC_IN));
				ax_s2[i] <= ax_s1[i];
			end
			// projection products
			op_s3 <= op_s2;
			side_s3 <= side_s2;
			f12_s3 <= f12_s2;
			for (int i = 0; i < 3; i++) begin
				pr_s3[i] <= PW'(w_s2[i]) * PW'(ax_s2[i]);
				w_s3[i] <= w_s2[i];
				ax_s3[i] <= ax_s2[i];
			end
			// m
			op_s4 <= op_s3;
			side_s4 <= side_s3;
			f12_s4 <= f12_s3;
			m_s4 <= MSW'(sat_sym(rnd_shr(64'(pr_s3[0]) + 64'(pr_s3[1]) + 64'(pr_s3[2]),
				FRAC_IN), 40));
			for (int i = 0; i < 3; i++) begin
				w_s4[i] <= w_s3[i];
				ax_s4[i] <= ax_s3[i];
			end
			// g before rounding
			op_s5 <= op_s4;
			side_s5 <= side_s4;
			prod_s5 <= PRW'(m_s4) * PRW'($signed({1'b0, f12_s4}));
			for (int i = 0; i < 3; i++) begin
				w_s5[i] <= w_s4[i];
				ax_s5[i] <= ax_s4[i];
			end
			// g
			op_s6 <= op_s5;
			side_s6 <= side_s5;
			g_s6 <= GW'(sat_sym(rnd_shr(64'(prod_s5), 12), 42));
			for (int i = 0; i < 3; i++) begin
				w_s6[i] <= w_s5[i];
				ax_s6[i] <= ax_s5[i];
			end
			// axial correction products
			op_s7 <= op_s6;
			side_s7 <= side_s6;
			for (int i = 0; i < 3; i++) begin
				gv_s7[i] <= GVW'(g_s6) * GVW'(ax_s6[i]);
				w_s7[i] <= w_s6[i];
			end
			// vector to normalize
			side_s8 <= side_s7;
			for (int i = 0; i < 3; i++) begin
				u_s8[i] <= (op_s7 == OP_SPHERE) ? UW'(w_s7[i]) :
					UW'(w_s7[i]) - UW'(rnd_shr(gv_s7[i], FRAC_IN));
			end
		end
	end

	assign out_valid = v_s8;
	assign u_vec = u_s8;
	assign side = side_s8;

endmodule

[rtl/qsn_norm.sv]
// Normalization front end: magnitudes, leading-one search, scaling and sum of squares.
// Depends on qsn_pkg.
module qsn_norm
	import qsn_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [2:0][UW-1:0]    u_vec,
	input  side_t                 side_in,
	output logic                  out_valid,
	output logic [SUMW-1:0]       sum,
	output logic [2:0][NMW-1:0]   nmag,
	output side_t                 side
);
	localparam int NCH = (MW + 7) / 8;
	localparam int PADW = NCH * 8;
	localparam int SQW = 2 * NMW;

	logic [MW-1:0]     mag_c [3];
	logic [PADW-1:0]   orv_c;
	logic [NCH-1:0]    nz_c;
	logic [2:0]        lp_c [NCH];
	side_t             side_c;
	logic [5:0]        pos_c;
	logic [MW-1:0]     sh_c;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	side_t side_s1, side_s2, side_s3, side_s4, side_s5;
	logic [MW-1:0]       mag_s1 [3], mag_s2 [3];
	logic [NCH-1:0]      nz_s1;
	logic [2:0]          lp_s1 [NCH];
	logic [5:0]          pos_s2;
	logic [2:0][NMW-1:0] nm_s3, nm_s4, nm_s5;
	logic [SQW-1:0]      sq_s4 [3];
	logic [SUMW-1:0]     sum_s5;

	always_comb begin
		side_c = side_in;
		orv_c = '0;
		for (int i = 0; i < 3; i++) begin
			side_c.neg[i] = u_vec[i][UW-1];
			mag_c[i] = u_vec[i][UW-1] ? MW'(-$signed(u_vec[i])) : u_vec[i][MW-1:0];
			orv_c = orv_c | PADW'(mag_c[i]);
		end
		side_c.zero = ~|orv_c;
		for (int c = 0; c < NCH; c++) begin
			nz_c[c] = |orv_c[c*8 +: 8];
			lp_c[c] = '0;
			for (int b = 0; b < 8; b++) begin
				if (orv_c[c*8+b]) begin
					lp_c[c] = 3'(b);
				end
			end
		end
	end

	always_comb begin
		pos_c = '0;
		for (int c = 0; c < NCH; c++) begin
			if (nz_s1[c]) begin
				pos_c = 6'(c * 8) + 6'(lp_s1[c]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3; v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_c;
			nz_s1 <= nz_c;
			for (int c = 0; c < NCH; c++) begin
				lp_s1[c] <= lp_c[c];
			end
			for (int i = 0; i < 3; i++) begin
				mag_s1[i] <= mag_c[i];
			end
			side_s2 <= side_s1;
			pos_s2 <= pos_c;
			for (int i = 0; i < 3; i++) begin
				mag_s2[i] <= mag_s1[i];
			end
			side_s3 <= side_s2;
			for (int i = 0; i < 3; i++) begin
				if (pos_s2 >= 6'(NMW - 1)) begin
					nm_s3[i] <= NMW'(mag_s2[i] >> (pos_s2 - 6'(NMW - 1)));
				end else begin
					nm_s3[i] <= NMW'(mag_s2[i] << (6'(NMW - 1) - pos_s2));
				end
			end
			side_s4 <= side_s3;
			nm_s4 <= nm_s3;
			for (int i = 0; i < 3; i++) begin
				sq_s4[i] <= SQW'(nm_s3[i]) * SQW'(nm_s3[i]);
			end
			side_s5 <= side_s4;
			nm_s5 <= nm_s4;
			sum_s5 <= SUMW'(sq_s4[0]) + SUMW'(sq_s4[1]) + SUMW'(sq_s4[2]);
		end
	end

	assign sh_c = '0;
	assign out_valid = v_s5;
	assign sum = sum_s5 | SUMW'(sh_c);
	assign nmag = nm_s5;
	assign side = side_s5;

endmodule

[rtl/qsn_sqrt.sv]
// Pipelined integer square root, four result bits per stage.
// Depends on qsn_pkg.
module qsn_sqrt
	import qsn_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [SUMW-1:0]       sum,
	input  logic [2:0][NMW-1:0]   nmag_in,
	input  side_t                 side_in,
	output logic                  out_valid,
	output logic [ROOTW-1:0]      root,
	output logic [2:0][NMW-1:0]   nmag,
	output side_t                 side
);
	localparam int STEPS = ROOTW;
	localparam int PER = 4;
	localparam int STG = (STEPS + PER - 1) / PER;
	localparam int RMW = ROOTW + 3;

	logic                 vld_s  [STG];
	logic [SUMW-1:0]      rad_s  [STG];
	logic [RMW-1:0]       rem_s  [STG];
	logic [ROOTW-1:0]     root_s [STG];
	logic [2:0][NMW-1:0]  nm_s   [STG];
	side_t                side_s [STG];

	for (genvar g = 0; g < STG; g++) begin : g_stage
		logic                vld_i;
		logic [SUMW-1:0]     rad_i, rad_n;
		logic [RMW-1:0]      rem_i, rem_n;
		logic [ROOTW-1:0]    root_i, root_n;
		logic [2:0][NMW-1:0] nm_i;
		side_t               side_i;

		if (g == 0) begin : g_head
			assign vld_i = in_valid;
			assign rad_i = sum;
			assign rem_i = '0;
			assign root_i = '0;
			assign nm_i = nmag_in;
			assign side_i = side_in;
		end else begin : g_body
			assign vld_i = vld_s[g-1];
			assign rad_i = rad_s[g-1];
			assign rem_i = rem_s[g-1];
			assign root_i = root_s[g-1];
			assign nm_i = nm_s[g-1];
			assign side_i = side_s[g-1];
		end

		always_comb begin
			rad_n = rad_i;
			rem_n = rem_i;
			root_n = root_i;
			for (int k = 0; k < PER; k++) begin
				if (g * PER + k < STEPS) begin
					rem_n = {rem_n[RMW-3:0], rad_n[SUMW-1 -: 2]};
					rad_n = rad_n << 2;
					if (rem_n >= RMW'({root_n, 2'b01})) begin
						rem_n = rem_n - RMW'({root_n, 2'b01});
						root_n = {root_n[ROOTW-2:0], 1'b1};
					end else begin
						root_n = {root_n[ROOTW-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[g] <= rad_n;
				rem_s[g] <= rem_n;
				root_s[g] <= root_n;
				nm_s[g] <= nm_i;
				side_s[g] <= side_i;
			end
		end
	end

	assign out_valid = vld_s[STG-1];
	assign root = root_s[STG-1];
	assign nmag = nm_s[STG-1];
	assign side = side_s[STG-1];

endmodule

[rtl/qsn_div.sv]
// Pipelined three-lane restoring divider: rounded component / length, four bits per stage.
// Depends on qsn_pkg.
module qsn_div
	import qsn_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [ROOTW-1:0]      len,
	input  logic [2:0][NMW-1:0]   nmag,
	input  side_t                 side_in,
	output logic                  out_valid,
	output logic [2:0][QW-1:0]    quo,
	output side_t                 side
);
	localparam int PER = 4;
	localparam int STG = (QW + PER - 1) / PER;

	logic                  vld_s  [STG];
	logic [ROOTW-1:0]      len_s  [STG];
	logic [2:0][NUMW-1:0]  rem_s  [STG];
	logic [2:0][QW-1:0]    q_s    [STG];
	side_t                 side_s [STG];

	for (genvar g = 0; g < STG; g++) begin : g_stage
		logic                 vld_i;
		logic [ROOTW-1:0]     len_i;
		logic [2:0][NUMW-1:0] rem_i, rem_n;
		logic [2:0][QW-1:0]   q_i, q_n;
		side_t                side_i;
		logic [NUMW:0]        dsh;

		if (g == 0) begin : g_head
			assign vld_i = in_valid;
			assign len_i = len;
			assign side_i = side_in;
			assign q_i = '0;
			for (genvar l = 0; l < 3; l++) begin : g_lane
				assign rem_i[l] = NUMW'({nmag[l], {NORMAL_FRAC_BITS{1'b0}}}) +
					NUMW'(len >> 1);
			end
		end else begin : g_body
			assign vld_i = vld_s[g-1];
			assign len_i = len_s[g-1];
			assign side_i = side_s[g-1];
			assign q_i = q_s[g-1];
			assign rem_i = rem_s[g-1];
		end

		always_comb begin
			rem_n = rem_i;
			q_n = q_i;
			dsh = '0;
			for (int k = 0; k < PER; k++) begin
				if (g * PER + k < QW) begin
					dsh = (NUMW+1)'(len_i) << (QW - 1 - (g * PER + k));
					for (int l = 0; l < 3; l++) begin
						if ({1'b0, rem_n[l]} >= dsh) begin
							rem_n[l] = rem_n[l] - NUMW'(dsh);
							q_n[l][QW - 1 - (g * PER + k)] = 1'b1;
						end
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				len_s[g] <= len_i;
				rem_s[g] <= rem_n;
				q_s[g] <= q_n;
				side_s[g] <= side_i;
			end
		end
	end

	assign out_valid = vld_s[STG-1];
	assign quo = q_s[STG-1];
	assign side = side_s[STG-1];

endmodule

[rtl/quadric_surface_normal_top.sv]
// Top level of the quadric surface normal block: channel ports, stage chain, output register.
// Depends on qsn_pkg, qsn_geom, qsn_norm, qsn_sqrt, qsn_div and the defines header.
//
// Usage:
//   Input channel s_*: one ray hit per transaction. s_tuser holds the object kind
//   (sphere, cylinder, cone, plane); s_tdata holds origin, direction, distance,
//   reference point, axis and cone slope.
//   Output channel m_*: one result per hit, in order. m_tdata holds the Q1.14 normal,
//   m_tuser flags a degenerate hit (zero vector, or zero axis for a plane), whose normal is zero.
//   Pipeline: 8 geometry stages, 5 normalization stages, 8 square-root stages,
//   4 divider stages, 1 output register.
//   Throughput: one transaction per cycle while the output is not stalled; every stage
//   is a register, and the square root and division give four result bits per stage.
//   Reset clears all valid bits; the pipe is empty and s_tready is high after reset.
//   When m_tready is low with a result waiting, the whole pipe holds and s_tready
//   drops in the same cycle; nothing is lost or repeated, and bubbles travel as
//   invalid slots.
`include "quadric_surface_normal_top_defines.svh"
module quadric_surface_normal_top
	import qsn_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	// ray_origin, ray_dir, hit_distance, obj_point, obj_axis, cone_slope, zero pad
	input  logic [295:0]  s_tdata,
	// opcode
	input  logic [1:0]    s_tuser,
	output logic          m_tvalid,
	input  logic          m_tready,
	// normal_x, normal_y, normal_z
	output logic [47:0]   m_tdata,
	// degenerate
	output logic [0:0]    m_tuser
);
	localparam int OFF_DIR = VEC_BITS;
	localparam int OFF_T   = 2 * VEC_BITS;
	localparam int OFF_PT  = OFF_T + 21;
	localparam int OFF_AX  = OFF_PT + VEC_BITS;
	localparam int OFF_K   = OFF_AX + VEC_BITS;
	localparam logic [QW-1:0] ONE_Q = QW'(1) << NORMAL_FRAC_BITS;
	localparam logic signed [OUTW-1:0] ONE_S = OUTW'(1) << NORMAL_FRAC_BITS;
	localparam logic signed [OUTW-1:0] HALF_S = OUTW'(1) << (NORMAL_FRAC_BITS - 1);

	logic en;
	logic geo_v, nrm_v, sq_v, div_v;
	logic [2:0][UW-1:0] u_vec;
	side_t geo_side, nrm_side, sq_side, div_side;
	logic [SUMW-1:0] sum;
	logic [2:0][NMW-1:0] nm_n, nm_q;
	logic [ROOTW-1:0] root;
	logic [2:0][QW-1:0] quo;

	logic [2:0][OUTW-1:0] comp_c;
	logic [QW-1:0] qc;
	logic deg_c;

	logic out_v_s, deg_s, plane_s;
	logic [2:0][OUTW-1:0] out_s;

	assign en = !out_v_s || m_tready;
	assign s_tready = en;

	qsn_geom u_geom (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (s_tvalid),
		.opcode       (op_t'(s_tuser)),
		.ray_origin   (s_tdata[VEC_BITS-1:0]),
		.ray_dir      (s_tdata[OFF_DIR +: VEC_BITS]),
		.hit_distance (s_tdata[OFF_T +: 21]),
		.obj_point    (s_tdata[OFF_PT +: VEC_BITS]),
		.obj_axis     (s_tdata[OFF_AX +: VEC_BITS]),
		.cone_slope   (s_tdata[OFF_K +: 16]),
		.out_valid    (geo_v),
		.u_vec        (u_vec),
		.side         (geo_side)
	);

	qsn_norm u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (geo_v),
		.u_vec     (u_vec),
		.side_in   (geo_side),
		.out_valid (nrm_v),
		.sum       (sum),
		.nmag      (nm_n),
		.side      (nrm_side)
	);

	qsn_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (nrm_v),
		.sum       (sum),
		.nmag_in   (nm_n),
		.side_in   (nrm_side),
		.out_valid (sq_v),
		.root      (root),
		.nmag      (nm_q),
		.side      (sq_side)
	);

	qsn_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_v),
		.len       (root),
		.nmag      (nm_q),
		.side_in   (sq_side),
		.out_valid (div_v),
		.quo       (quo),
		.side      (div_side)
	);

	always_comb begin
		deg_c = 1'b0;
		qc = '0;
		for (int i = 0; i < 3; i++) begin
			qc = (quo[i] > ONE_Q) ? ONE_Q : quo[i];
			comp_c[i] = div_side.neg[i] ? -OUTW'(qc) : OUTW'(qc);
		end
		if (div_side.plane) begin
			comp_c = div_side.pn;
			deg_c = div_side.pdeg;
		end else if (div_side.zero) begin
			comp_c = '0;
			deg_c = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_s <= 1'b0;
		end else if (en) begin
			out_v_s <= div_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_s <= comp_c;
			deg_s <= deg_c;
			plane_s <= div_side.plane;
		end
	end

	assign m_tvalid = out_v_s;
	assign m_tdata = out_s;
	assign m_tuser = deg_s;

	`QSN_ASSERT_IMP(a_deg_zero, out_v_s && deg_s, out_s == '0, "degenerate result with nonzero normal")
	`QSN_ASSERT_IMP(a_unit_range, out_v_s, ($signed(out_s[0]) <= ONE_S) && ($signed(out_s[0]) >= -ONE_S) && ($signed(out_s[1]) <= ONE_S) && ($signed(out_s[1]) >= -ONE_S) && ($signed(out_s[2]) <= ONE_S) && ($signed(out_s[2]) >= -ONE_S), "normal component beyond unit range")
	`QSN_ASSERT_IMP(a_norm_big, out_v_s && !deg_s && !plane_s, ($signed(out_s[0]) >= HALF_S) || ($signed(out_s[0]) <= -HALF_S) || ($signed(out_s[1]) >= HALF_S) || ($signed(out_s[1]) <= -HALF_S) || ($signed(out_s[2]) >= HALF_S) || ($signed(out_s[2]) <= -HALF_S), "normalized vector too short")
	`QSN_ASSERT_IMP(a_no_drop, $fell(m_tvalid), $past(m_tready), "result dropped before transaction")

endmodule
